// ===== rtl/gecf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gecf_pkg
// Shared constants and types of the gradient edge contour filter.
// ----------------------------------------------------------------------------
package gecf_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int PIX_W      = 16;
	localparam int EDGE_W     = PIX_W + 1;
	localparam int CFG_W      = 16;
	localparam int IDX_W      = 2;
	localparam int WCFG_W     = 10;
	localparam int HCFG_W     = 13;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX_GREY     = 2'd2;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [EDGE_W-1:0] edge_value;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              frame_end;
	} result_t;

endpackage

// ===== rtl/gradient_edge_contour_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_edge_contour_filter
// Forward-difference gradient edge filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// output: a result is presented in the cycle after its pixel is accepted
// throughput: one pixel per cycle while out_ready is high; in the last row
//   (not row 0) two results per pixel, so in_ready waits on the second word
// reset: counters clear, geometry 512 x 512, max grey 255; line cells are
//   not cleared and are fully rewritten before an interior result uses them
module gradient_edge_contour_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gecf_pkg::IDX_W-1:0]        cfg_index,
	input  logic [gecf_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [gecf_pkg::PIX_W-1:0]        pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gecf_pkg::EDGE_W-1:0]       edge_value,
	output logic [gecf_pkg::ROW_W-1:0]        out_row,
	output logic [gecf_pkg::COL_W-1:0]        out_col,
	output logic                              frame_end
);

	logic [gecf_pkg::COL_W-1:0]  w_m1_q;
	logic [gecf_pkg::COL_W-1:0]  inj_q;
	logic [gecf_pkg::ROW_W-1:0]  h_m1_q;
	logic [gecf_pkg::PIX_W-1:0]  max_grey_q;
	logic [gecf_pkg::COL_W-1:0]  col_q;
	logic [gecf_pkg::ROW_W-1:0]  row_q;
	logic [1:0]                  cnt_q;
	gecf_pkg::result_t           slot_a_q;
	gecf_pkg::result_t           slot_b_q;

	logic [gecf_pkg::WCFG_W-1:0] wcfg;
	logic [gecf_pkg::HCFG_W-1:0] hcfg;
	logic [gecf_pkg::COL_W-1:0]  w_m1_new;
	logic [gecf_pkg::ROW_W-1:0]  h_m1_new;
	logic                        in_fire;
	logic                        out_fire;
	gecf_pkg::pix_t              cur;
	gecf_pkg::pix_t              right;
	logic                        has_prev;
	logic                        is_last;
	logic                        last_col;
	logic [gecf_pkg::ROW_W-1:0]  prev_row;
	logic                        border;
	logic [gecf_pkg::PIX_W-1:0]  diff_down;
	logic [gecf_pkg::PIX_W-1:0]  diff_right;
	logic [gecf_pkg::EDGE_W-1:0] grad;
	gecf_pkg::result_t           res_prev;
	gecf_pkg::result_t           res_last;
	logic [1:0]                  n_res;

	// effective geometry from the written values
	assign wcfg = cfg_data[gecf_pkg::WCFG_W-1:0];
	assign hcfg = cfg_data[gecf_pkg::HCFG_W-1:0];

	always_comb begin
		if (wcfg == '0) begin
			w_m1_new = '0;
		end else if (wcfg > gecf_pkg::WCFG_W'(gecf_pkg::MAX_WIDTH)) begin
			w_m1_new = gecf_pkg::COL_W'(gecf_pkg::MAX_WIDTH - 1);
		end else begin
			w_m1_new = gecf_pkg::COL_W'(wcfg - 1'b1);
		end
		if (hcfg == '0) begin
			h_m1_new = '0;
		end else if (hcfg > gecf_pkg::HCFG_W'(gecf_pkg::MAX_HEIGHT)) begin
			h_m1_new = gecf_pkg::ROW_W'(gecf_pkg::MAX_HEIGHT - 1);
		end else begin
			h_m1_new = gecf_pkg::ROW_W'(hcfg - 1'b1);
		end
	end

	assign in_ready  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_fire  = out_valid && out_ready;

	gecf_line u_line (
		.clk   (clk),
		.en    (in_fire),
		.inj   (inj_q),
		.pixel (pixel),
		.cur   (cur),
		.right (right)
	);

	// gradient of the pixel one row up
	assign has_prev   = (row_q != '0);
	assign is_last    = (row_q == h_m1_q);
	assign last_col   = (col_q == w_m1_q);
	assign prev_row   = row_q - 1'b1;
	assign border     = (prev_row == '0) || (col_q == '0) || last_col;
	assign diff_down  = (pixel > cur) ? pixel - cur : cur - pixel;
	assign diff_right = (right > cur) ? right - cur : cur - right;
	assign grad       = {1'b0, diff_down} + {1'b0, diff_right};

	always_comb begin
		res_prev.edge_value = border ? {1'b0, max_grey_q} : grad;
		res_prev.row        = prev_row;
		res_prev.col        = col_q;
		res_prev.frame_end  = 1'b0;
		res_last.edge_value = {1'b0, max_grey_q};
		res_last.row        = row_q;
		res_last.col        = col_q;
		res_last.frame_end  = last_col;
		n_res               = {1'b0, has_prev} + {1'b0, is_last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_m1_q     <= gecf_pkg::COL_W'(gecf_pkg::MAX_WIDTH - 1);
			inj_q      <= '0;
			h_m1_q     <= gecf_pkg::ROW_W'(511);
			max_grey_q <= gecf_pkg::PIX_W'(255);
			col_q      <= '0;
			row_q      <= '0;
			cnt_q      <= 2'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gecf_pkg::REG_FRAME_WIDTH: begin
						w_m1_q <= w_m1_new;
						inj_q  <= gecf_pkg::COL_W'(gecf_pkg::MAX_WIDTH - 1) - w_m1_new;
						col_q  <= '0;
						row_q  <= '0;
					end
					gecf_pkg::REG_FRAME_HEIGHT: begin
						h_m1_q <= h_m1_new;
						col_q  <= '0;
						row_q  <= '0;
					end
					gecf_pkg::REG_MAX_GREY: begin
						max_grey_q <= cfg_data[gecf_pkg::PIX_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (in_fire) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= is_last ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (in_fire) begin
				cnt_q <= n_res;
			end else if (out_fire) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// result slots: a is presented, b waits behind it
	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_a_q <= has_prev ? res_prev : res_last;
			slot_b_q <= res_last;
		end else if (out_fire) begin
			slot_a_q <= slot_b_q;
		end
	end

	assign edge_value = slot_a_q.edge_value;
	assign out_row    = slot_a_q.row;
	assign out_col    = slot_a_q.col;
	assign frame_end  = slot_a_q.frame_end;

endmodule

// ===== rtl/gecf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gecf_cell
// One pixel cell of the line delay: loads the new pixel or its neighbor.
// ----------------------------------------------------------------------------
module gecf_cell (
	input  logic          clk,
	input  logic          en,
	input  logic          load,
	input  gecf_pkg::pix_t pixel,
	input  gecf_pkg::pix_t prev,
	output gecf_pkg::pix_t data
);

	gecf_pkg::pix_t data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= load ? pixel : prev;
		end
	end

	assign data = data_q;

endmodule

// ===== rtl/gecf_line.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gecf_line
// Row of pixel cells forming a one-line delay of programmable length.
// ----------------------------------------------------------------------------
module gecf_line (
	input  logic                       clk,
	input  logic                       en,
	input  logic [gecf_pkg::COL_W-1:0] inj,
	input  gecf_pkg::pix_t             pixel,
	output gecf_pkg::pix_t             cur,
	output gecf_pkg::pix_t             right
);

	gecf_pkg::pix_t chain [gecf_pkg::MAX_WIDTH];

	for (genvar i = 0; i < gecf_pkg::MAX_WIDTH; i++) begin : g_cell
		gecf_pkg::pix_t prev;
		logic           load;

		if (i == 0) begin : g_first
			assign prev = pixel;
		end else begin : g_rest
			assign prev = chain[i-1];
		end

		assign load = (inj == gecf_pkg::COL_W'(i));

		gecf_cell u_cell (
			.clk   (clk),
			.en    (en),
			.load  (load),
			.pixel (pixel),
			.prev  (prev),
			.data  (chain[i])
		);
	end

	// last cell holds the pixel one line back, the one before it its right neighbor
	assign cur   = chain[gecf_pkg::MAX_WIDTH-1];
	assign right = chain[gecf_pkg::MAX_WIDTH-2];

endmodule

// ===== tb/sv/gecf_edge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gecf_edge_checker
// Watches the register port and both word channels of the gradient edge
// contour filter. It keeps its own copy of the previous row, the row and
// column counters and the three registers. For every accepted pixel it works
// out the result words, and it checks each accepted result word field by
// field against the oldest word still owed.
// ----------------------------------------------------------------------------
module gecf_edge_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gecf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [gecf_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [gecf_pkg::PIX_W-1:0]  pixel,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [gecf_pkg::EDGE_W-1:0] edge_value,
	input  logic [gecf_pkg::ROW_W-1:0]  out_row,
	input  logic [gecf_pkg::COL_W-1:0]  out_col,
	input  logic                        frame_end,
	output int                          errors,
	output int                          pending
);

	gecf_pkg::pix_t              prev_line [gecf_pkg::MAX_WIDTH];
	int unsigned                 col_cnt;
	int unsigned                 row_cnt;
	logic [gecf_pkg::WCFG_W-1:0] width_reg;
	logic [gecf_pkg::HCFG_W-1:0] height_reg;
	logic [gecf_pkg::PIX_W-1:0]  grey_reg;
	gecf_pkg::result_t           edge_q [$];
	gecf_pkg::result_t           want;

	function automatic int unsigned grey_dist(input int unsigned a, input int unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			errors = errors + 1;
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
		end
	endfunction

	task automatic predict_edges(input gecf_pkg::pix_t px);
		int unsigned       w;
		int unsigned       h;
		int unsigned       c;
		int unsigned       r;
		int unsigned       v;
		gecf_pkg::result_t res;
		w = int'(width_reg);
		h = int'(height_reg);
		if (w == 0) w = 1;
		if (w > gecf_pkg::MAX_WIDTH) w = gecf_pkg::MAX_WIDTH;
		if (h == 0) h = 1;
		if (h > gecf_pkg::MAX_HEIGHT) h = gecf_pkg::MAX_HEIGHT;
		c = col_cnt;
		r = row_cnt;
		if (c >= w) c = w - 1;
		if (r >= h) r = h - 1;

		// word for the row above
		if (r >= 1) begin
			if (r == 1 || c == 0 || c == w - 1) begin
				v = int'(grey_reg);
			end else begin
				v = grey_dist(int'(px), int'(prev_line[c]))
					+ grey_dist(int'(prev_line[c + 1]), int'(prev_line[c]));
			end
			res.edge_value = gecf_pkg::EDGE_W'(v);
			res.row        = gecf_pkg::ROW_W'(r - 1);
			res.col        = gecf_pkg::COL_W'(c);
			res.frame_end  = 1'b0;
			edge_q.push_back(res);
		end

		// last row is all border
		if (r == h - 1) begin
			res.edge_value = gecf_pkg::EDGE_W'(grey_reg);
			res.row        = gecf_pkg::ROW_W'(r);
			res.col        = gecf_pkg::COL_W'(c);
			res.frame_end  = (c == w - 1);
			edge_q.push_back(res);
		end

		prev_line[c] = px;
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
			row_cnt = r;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q.delete();
			col_cnt    = 0;
			row_cnt    = 0;
			width_reg  = 10'd512;
			height_reg = 13'd512;
			grey_reg   = 16'd255;
			errors     = 0;
			pending   <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gecf_pkg::REG_FRAME_WIDTH: begin
						width_reg = cfg_data[gecf_pkg::WCFG_W-1:0];
						col_cnt   = 0;
						row_cnt   = 0;
					end
					gecf_pkg::REG_FRAME_HEIGHT: begin
						height_reg = cfg_data[gecf_pkg::HCFG_W-1:0];
						col_cnt    = 0;
						row_cnt    = 0;
					end
					gecf_pkg::REG_MAX_GREY: begin
						grey_reg = cfg_data;
					end
					default: begin
					end
				endcase
			end

			if (out_valid && out_ready) begin
				if (edge_q.size() == 0) begin
					errors = errors + 1;
					$display("%0t: expected no word, actual edge_value %0d row %0d col %0d end %0b",
						$time, edge_value, out_row, out_col, frame_end);
				end else begin
					want = edge_q.pop_front();
					check_field("edge_value", 32'(want.edge_value), 32'(edge_value));
					check_field("out_row", 32'(want.row), 32'(out_row));
					check_field("out_col", 32'(want.col), 32'(out_col));
					check_field("frame_end", 32'(want.frame_end), 32'(frame_end));
				end
			end

			if (in_valid && in_ready) predict_edges(pixel);
			pending <= edge_q.size();
		end
	end

endmodule

// ===== tb/sv/gradient_edge_contour_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_edge_contour_filter_tb
// Streams grey frames into the gradient edge contour filter under a range of
// geometries and border values, with random gaps on the pixel side and random
// stalls on the result side. A checker beside the block predicts and compares
// every result word; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module gradient_edge_contour_filter_tb;

	localparam logic [gecf_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [gecf_pkg::IDX_W-1:0]  cfg_index;
	logic [gecf_pkg::CFG_W-1:0]  cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic [gecf_pkg::PIX_W-1:0]  pixel;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [gecf_pkg::EDGE_W-1:0] edge_value;
	logic [gecf_pkg::ROW_W-1:0]  out_row;
	logic [gecf_pkg::COL_W-1:0]  out_col;
	logic                        frame_end;
	int unsigned                 idle_pct = 24;
	int                          errors;
	int                          pending;

	gradient_edge_contour_filter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_value (edge_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_end  (frame_end)
	);

	gecf_edge_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_value (edge_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_end  (frame_end),
		.errors     (errors),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= idle_pct);
	end

	function automatic gecf_pkg::pix_t rand_pixel();
		case ($urandom_range(9, 0))
			0: return '0;
			1: return '1;
			2: return gecf_pkg::PIX_W'($urandom_range(16, 0));
			default: return gecf_pkg::PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [gecf_pkg::CFG_W-1:0] rand_grey();
		case ($urandom_range(5, 0))
			0: return '1;
			1: return gecf_pkg::CFG_W'(1);
			default: return gecf_pkg::CFG_W'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input gecf_pkg::pix_t v);
		while ($urandom_range(99, 0) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic stream(input int unsigned n);
		repeat (n) send_pixel(rand_pixel());
	endtask

	// hold the pixel side until every owed word is out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gecf_pkg::IDX_W-1:0] idx,
			input logic [gecf_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned w, input int unsigned h,
			input logic [gecf_pkg::CFG_W-1:0] g);
		drain();
		write_reg(gecf_pkg::REG_FRAME_WIDTH, gecf_pkg::CFG_W'(w));
		write_reg(gecf_pkg::REG_FRAME_HEIGHT, gecf_pkg::CFG_W'(h));
		write_reg(gecf_pkg::REG_MAX_GREY, g);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned n;
		int unsigned rand_items;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = gecf_pkg::REG_FRAME_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		pixel     = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry, row 0 gives no word
		stream(8);

		// one interior pixel pushed to the largest sum, then wrap
		configure(3, 3, 16'hFFFF);
		send_pixel(16'd7);
		send_pixel(16'd100);
		send_pixel(16'd9);
		send_pixel(16'd123);
		send_pixel(16'd0);
		send_pixel(16'hFFFF);
		send_pixel(16'd5);
		send_pixel(16'hFFFF);
		send_pixel(16'd0);
		send_pixel(16'd42);

		// zero geometry acts as 1 x 1
		configure(0, 0, 16'd1);
		send_pixel(16'hFFFF);
		send_pixel(16'd0);

		// unused index is ignored, grey alone keeps the frame going
		drain();
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(gecf_pkg::REG_MAX_GREY, 16'd0);
		cfg_we <= 1'b0;
		stream(2);

		configure(2, 2, 16'h8000);
		stream(4);
		configure(4, 1, 16'hFFFF);
		stream(4);

		configure(5, 3, 16'd200);
		stream(7);
		drain();
		write_reg(gecf_pkg::REG_MAX_GREY, 16'd1);
		cfg_we <= 1'b0;
		stream(9);

		// height beyond the limit
		configure(2, 8191, 16'h5AA5);
		stream(8);

		// no idling on either side
		idle_pct = 0;
		configure(24, 4, 16'hFFFF);
		stream(96);
		idle_pct = 24;

		rand_items = 0;
		while (rand_items < 250) begin
			case ($urandom_range(9, 0))
				0: w = $urandom_range(2, 1);
				1: w = $urandom_range(24, 9);
				default: w = $urandom_range(8, 3);
			endcase
			h = ($urandom_range(3, 0) == 0) ? $urandom_range(8, 1) : $urandom_range(5, 2);
			if ($urandom_range(4, 0) == 0) begin
				drain();
				write_reg(gecf_pkg::REG_MAX_GREY, rand_grey());
				cfg_we <= 1'b0;
				n = $urandom_range(40, 1);
			end else begin
				configure(w, h, rand_grey());
				n = $urandom_range(2, 1) * w * h;
				if ($urandom_range(3, 0) == 0) n = n + $urandom_range(w * h - 1, 1);
			end
			stream(n);
			rand_items = rand_items + n;
		end

		drain();
		repeat (16) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
